[rtl/pscc_pkg.sv]
package pscc_pkg;

   localparam int GAIN_W = 32;
   localparam int LIMIT_W = 31;
   localparam int DRIVE_W = 15;
   localparam int INTEG_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_SPEED_WIDTH = 16;
   localparam int DEF_GAIN_FRAC_BITS = 24;

   localparam int DRIVE_FRAC_BITS = 15;
   localparam int PROD_LIMIT_LOG = 61;
   localparam int CLIP_W = PROD_LIMIT_LOG + 2;
   localparam int TOTAL_W = CLIP_W + 2;
   localparam int BIG_SUM_LOG = 40;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET = 32'sd24466;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RESET = 32'sd153;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RESET = 32'sd0;
   localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 31'd10000;
   localparam logic [DRIVE_W-1:0] MAX_DRIVE_RESET = 15'd30801;
   localparam logic [DRIVE_W-1:0] MIN_DRIVE_RESET = 15'd8192;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN,
      CSR_INTEG_GAIN,
      CSR_DERIV_GAIN,
      CSR_INTEGRAL_LIMIT,
      CSR_MAX_DRIVE,
      CSR_MIN_DRIVE
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       integral_limit;
      logic [DRIVE_W-1:0]       max_drive;
      logic [DRIVE_W-1:0]       min_drive;
   } csr_regs_type;

   function automatic int err_width(input int speed_width);
      return speed_width + 1;
   endfunction

   function automatic int sum_width(input int speed_width);
      int e;
      e = speed_width + 1;
      return ((e > INTEG_W) ? e : INTEG_W) + 1;
   endfunction

endpackage

[rtl/pscc_req_if.sv]
interface pscc_req_if #(
   parameter int SPEED_WIDTH = pscc_pkg::DEF_SPEED_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic signed [SPEED_WIDTH-1:0] target_speed;
   logic signed [SPEED_WIDTH-1:0] measured_speed;

   modport source (output valid, op, target_speed, measured_speed, input ready);
   modport sink (input valid, op, target_speed, measured_speed, output ready);
endinterface

[rtl/pscc_rsp_if.sv]
interface pscc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pscc_pkg::DRIVE_W-1:0]  drive;

   modport source (output valid, drive, input ready);
   modport sink (input valid, drive, output ready);
endinterface

[rtl/pscc_csr.sv]
module pscc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [pscc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [pscc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output pscc_pkg::csr_regs_type            regs
);

   pscc_pkg::csr_regs_type regs_ff;

   assign regs = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.prop_gain <= pscc_pkg::PROP_GAIN_RESET;
         regs_ff.integ_gain <= pscc_pkg::INTEG_GAIN_RESET;
         regs_ff.deriv_gain <= pscc_pkg::DERIV_GAIN_RESET;
         regs_ff.integral_limit <= pscc_pkg::INTEGRAL_LIMIT_RESET;
         regs_ff.max_drive <= pscc_pkg::MAX_DRIVE_RESET;
         regs_ff.min_drive <= pscc_pkg::MIN_DRIVE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pscc_pkg::CSR_PROP_GAIN: begin
               regs_ff.prop_gain <= csr_write_data[pscc_pkg::GAIN_W-1:0];
            end
            pscc_pkg::CSR_INTEG_GAIN: begin
               regs_ff.integ_gain <= csr_write_data[pscc_pkg::GAIN_W-1:0];
            end
            pscc_pkg::CSR_DERIV_GAIN: begin
               regs_ff.deriv_gain <= csr_write_data[pscc_pkg::GAIN_W-1:0];
            end
            pscc_pkg::CSR_INTEGRAL_LIMIT: begin
               regs_ff.integral_limit <= csr_write_data[pscc_pkg::LIMIT_W-1:0];
            end
            pscc_pkg::CSR_MAX_DRIVE: begin
               regs_ff.max_drive <= csr_write_data[pscc_pkg::DRIVE_W-1:0];
            end
            pscc_pkg::CSR_MIN_DRIVE: begin
               regs_ff.min_drive <= csr_write_data[pscc_pkg::DRIVE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/pscc_front.sv]
module pscc_front #(
   parameter int SPEED_WIDTH = pscc_pkg::DEF_SPEED_WIDTH,
   localparam int ERR_W = pscc_pkg::err_width(SPEED_WIDTH),
   localparam int SUM_W = pscc_pkg::sum_width(SPEED_WIDTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   pscc_req_if.sink                    req_bus,
   input  pscc_pkg::csr_regs_type      csr,
   output logic                        s1_valid,
   input  logic                        s1_ready,
   output logic signed [ERR_W-1:0]     s1_err,
   output logic signed [ERR_W-1:0]     s1_vel,
   output logic signed [SUM_W-1:0]     s1_sum
);

   localparam int INTEG_W = pscc_pkg::INTEG_W;

   logic signed [INTEG_W-1:0]     integral_ff, integral_in;
   logic signed [SPEED_WIDTH-1:0] prev_meas_ff;
   logic                          s1_valid_ff;
   logic signed [ERR_W-1:0]       s1_err_ff, s1_vel_ff;
   logic signed [SUM_W-1:0]       s1_sum_ff;
   logic signed [ERR_W-1:0]       err, vel;
   logic signed [SUM_W-1:0]       sum, halved, limit_ext, floor_ext;
   logic                          ready, accept, is_clear;

   assign ready = !s1_valid_ff || s1_ready;
   assign req_bus.ready = ready;
   assign accept = req_bus.valid && ready;
   assign is_clear = (req_bus.op == pscc_pkg::OP_CLEAR);

   assign s1_valid = s1_valid_ff;
   assign s1_err = s1_err_ff;
   assign s1_vel = s1_vel_ff;
   assign s1_sum = s1_sum_ff;

   always_comb begin
      err = $signed({req_bus.target_speed[SPEED_WIDTH-1], req_bus.target_speed})
          - $signed({req_bus.measured_speed[SPEED_WIDTH-1], req_bus.measured_speed});
      vel = $signed({req_bus.measured_speed[SPEED_WIDTH-1], req_bus.measured_speed})
          - $signed({prev_meas_ff[SPEED_WIDTH-1], prev_meas_ff});
      sum = $signed({{(SUM_W-INTEG_W){integral_ff[INTEG_W-1]}}, integral_ff})
          + $signed({{(SUM_W-ERR_W){err[ERR_W-1]}}, err});
      halved = err[ERR_W-1] ? (sum >>> 1) : sum;
      limit_ext = $signed({{(SUM_W-pscc_pkg::LIMIT_W){1'b0}}, csr.integral_limit});
      floor_ext = $signed({{(SUM_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}});
      priority if (halved > limit_ext) begin
         integral_in = limit_ext[INTEG_W-1:0];
      end else if (halved < floor_ext) begin
         integral_in = floor_ext[INTEG_W-1:0];
      end else begin
         integral_in = halved[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_meas_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (is_clear) begin
               integral_ff <= '0;
            end else begin
               integral_ff <= integral_in;
               prev_meas_ff <= req_bus.measured_speed;
            end
         end
         if (ready) begin
            s1_valid_ff <= accept && !is_clear;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_clear) begin
         s1_err_ff <= err;
         s1_vel_ff <= vel;
         s1_sum_ff <= sum;
      end
   end

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      accept && is_clear |=> integral_ff == '0 && !s1_valid_ff)
      else $error("clear transaction did not zero the integral");

   a_update_enters: assert property (@(posedge clock) disable iff (reset)
      accept && !is_clear |=> s1_valid_ff && s1_err_ff == $past(err))
      else $error("update transaction did not enter the pipeline");

endmodule

[rtl/pscc_mul.sv]
module pscc_mul #(
   parameter int SPEED_WIDTH = pscc_pkg::DEF_SPEED_WIDTH,
   localparam int ERR_W = pscc_pkg::err_width(SPEED_WIDTH),
   localparam int SUM_W = pscc_pkg::sum_width(SPEED_WIDTH),
   localparam int PE_W = pscc_pkg::GAIN_W + ERR_W,
   localparam int PS_W = pscc_pkg::GAIN_W + SUM_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pscc_pkg::csr_regs_type      csr,
   input  logic                        s1_valid,
   output logic                        s1_ready,
   input  logic signed [ERR_W-1:0]     s1_err,
   input  logic signed [ERR_W-1:0]     s1_vel,
   input  logic signed [SUM_W-1:0]     s1_sum,
   output logic                        s2_valid,
   input  logic                        s2_ready,
   output logic signed [PE_W-1:0]      s2_prop,
   output logic signed [PE_W-1:0]      s2_deriv,
   output logic signed [PS_W-1:0]      s2_integ
);

   logic                   s2_valid_ff;
   logic signed [PE_W-1:0] prop_ff, deriv_ff, prop_in, deriv_in;
   logic signed [PS_W-1:0] integ_ff, integ_in;
   logic                   load;

   assign s1_ready = !s2_valid_ff || s2_ready;
   assign load = s1_valid && s1_ready;

   assign prop_in = PE_W'(csr.prop_gain) * PE_W'(s1_err);
   assign deriv_in = PE_W'(csr.deriv_gain) * PE_W'(s1_vel);
   assign integ_in = PS_W'(csr.integ_gain) * PS_W'(s1_sum);

   assign s2_valid = s2_valid_ff;
   assign s2_prop = prop_ff;
   assign s2_deriv = deriv_ff;
   assign s2_integ = integ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prop_ff <= prop_in;
         deriv_ff <= deriv_in;
         integ_ff <= integ_in;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ready |=> s2_valid_ff && $stable(integ_ff) && $stable(prop_ff))
      else $error("stalled products changed");

endmodule

[rtl/pscc_back.sv]
module pscc_back #(
   parameter int SPEED_WIDTH = pscc_pkg::DEF_SPEED_WIDTH,
   parameter int GAIN_FRAC_BITS = pscc_pkg::DEF_GAIN_FRAC_BITS,
   localparam int ERR_W = pscc_pkg::err_width(SPEED_WIDTH),
   localparam int SUM_W = pscc_pkg::sum_width(SPEED_WIDTH),
   localparam int PE_W = pscc_pkg::GAIN_W + ERR_W,
   localparam int PS_W = pscc_pkg::GAIN_W + SUM_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pscc_pkg::csr_regs_type      csr,
   input  logic                        s2_valid,
   output logic                        s2_ready,
   input  logic signed [PE_W-1:0]      s2_prop,
   input  logic signed [PE_W-1:0]      s2_deriv,
   input  logic signed [PS_W-1:0]      s2_integ,
   pscc_rsp_if.source                  rsp_bus
);

   localparam int CLIP_W = pscc_pkg::CLIP_W;
   localparam int TOTAL_W = pscc_pkg::TOTAL_W;
   localparam int DRIVE_W = pscc_pkg::DRIVE_W;
   localparam int SHIFT = GAIN_FRAC_BITS - pscc_pkg::DRIVE_FRAC_BITS;
   localparam int SHR = (SHIFT >= 0) ? SHIFT : 0;
   localparam int SHL = (SHIFT < 0) ? -SHIFT : 0;

   function automatic logic signed [CLIP_W-1:0] clip_prod(input logic signed [PS_W-1:0] p);
      logic signed [PS_W-1:0] lim_pos, lim_neg;
      lim_pos = $signed({{(PS_W-pscc_pkg::PROD_LIMIT_LOG-1){1'b0}}, 1'b1,
                         {pscc_pkg::PROD_LIMIT_LOG{1'b0}}});
      lim_neg = -lim_pos;
      if (p > lim_pos) begin
         return lim_pos[CLIP_W-1:0];
      end else if (p < lim_neg) begin
         return lim_neg[CLIP_W-1:0];
      end
      return p[CLIP_W-1:0];
   endfunction

   logic                      s3_valid_ff, out_valid_ff;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic [DRIVE_W-1:0]        drive_ff, drive_in, clipped;
   logic signed [CLIP_W-1:0]  c_prop, c_deriv, c_integ;
   logic signed [TOTAL_W-1:0] scaled, max_ext, big_lim;
   logic                      s3_ready, out_en, big, non_positive;

   assign out_en = !out_valid_ff || rsp_bus.ready;
   assign s3_ready = !s3_valid_ff || out_en;
   assign s2_ready = s3_ready;

   always_comb begin
      c_prop = clip_prod($signed({{(PS_W-PE_W){s2_prop[PE_W-1]}}, s2_prop}));
      c_deriv = clip_prod($signed({{(PS_W-PE_W){s2_deriv[PE_W-1]}}, s2_deriv}));
      c_integ = clip_prod(s2_integ);
      total_in = $signed({{(TOTAL_W-CLIP_W){c_prop[CLIP_W-1]}}, c_prop})
               + $signed({{(TOTAL_W-CLIP_W){c_deriv[CLIP_W-1]}}, c_deriv})
               + $signed({{(TOTAL_W-CLIP_W){c_integ[CLIP_W-1]}}, c_integ});
   end

   always_comb begin
      non_positive = total_ff[TOTAL_W-1] || (total_ff == '0);
      scaled = (total_ff >>> SHR) <<< SHL;
      big_lim = $signed({{(TOTAL_W-pscc_pkg::BIG_SUM_LOG-1){1'b0}}, 1'b1,
                         {pscc_pkg::BIG_SUM_LOG{1'b0}}});
      big = (SHL != 0) && (total_ff > big_lim);
      max_ext = $signed({{(TOTAL_W-DRIVE_W){1'b0}}, csr.max_drive});
      priority if (non_positive) begin
         clipped = '0;
      end else if (big || scaled >= max_ext) begin
         clipped = csr.max_drive;
      end else begin
         clipped = scaled[DRIVE_W-1:0];
      end
      if (clipped != '0 && clipped <= csr.min_drive) begin
         drive_in = csr.min_drive;
      end else begin
         drive_in = clipped;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.drive = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= s2_valid;
         end
         if (out_en) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid && s3_ready) begin
         total_ff <= total_in;
      end
      if (s3_valid_ff && out_en) begin
         drive_ff <= drive_in;
      end
   end

   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_en |=> s3_valid_ff && $stable(total_ff))
      else $error("stalled sum changed");

   a_negative_zero: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && out_en && non_positive |=> out_valid_ff && drive_ff == '0)
      else $error("non-positive sum gave a nonzero drive");

endmodule

[rtl/pid_speed_controller_clamped.sv]
// Channel   Interface      Role    Payload
// req_bus   pscc_req_if    sink    op, target_speed, measured_speed
// rsp_bus   pscc_rsp_if    source  drive
// csr_*     write port     input   csr_write_enable, csr_index, csr_write_data
//
// One transaction is accepted every cycle while the pipeline is not stalled; an update passes
// through the integral stage, the product registers, the sum register and the drive register.
// A clear transaction gives no result and takes effect for the next update at once.
// Reset is synchronous and active high; it clears the integral, the last measurement,
// all valid bits and loads the register defaults.
// A stalled rsp_bus holds the pipeline; req_bus stays ready while any stage is empty.
module pid_speed_controller_clamped #(
   parameter int SPEED_WIDTH = pscc_pkg::DEF_SPEED_WIDTH,
   parameter int GAIN_FRAC_BITS = pscc_pkg::DEF_GAIN_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   pscc_req_if.sink                        req_bus,
   pscc_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [pscc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [pscc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int ERR_W = pscc_pkg::err_width(SPEED_WIDTH);
   localparam int SUM_W = pscc_pkg::sum_width(SPEED_WIDTH);
   localparam int PE_W = pscc_pkg::GAIN_W + ERR_W;
   localparam int PS_W = pscc_pkg::GAIN_W + SUM_W;

   pscc_pkg::csr_regs_type  regs;
   logic                    s1_valid, s1_ready, s2_valid, s2_ready;
   logic signed [ERR_W-1:0] s1_err, s1_vel;
   logic signed [SUM_W-1:0] s1_sum;
   logic signed [PE_W-1:0]  s2_prop, s2_deriv;
   logic signed [PS_W-1:0]  s2_integ;

   pscc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .regs             (regs)
   );

   pscc_front #(
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr      (regs),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_err   (s1_err),
      .s1_vel   (s1_vel),
      .s1_sum   (s1_sum)
   );

   pscc_mul #(
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .csr      (regs),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_err   (s1_err),
      .s1_vel   (s1_vel),
      .s1_sum   (s1_sum),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready),
      .s2_prop  (s2_prop),
      .s2_deriv (s2_deriv),
      .s2_integ (s2_integ)
   );

   pscc_back #(
      .SPEED_WIDTH    (SPEED_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (regs),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready),
      .s2_prop  (s2_prop),
      .s2_deriv (s2_deriv),
      .s2_integ (s2_integ),
      .rsp_bus  (rsp_bus)
   );

endmodule
